// ----- rtl/ilha_pkg.sv -----
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared constants and types of the implicit-list heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

  localparam int unsigned HEAP_WORDS_DEF = 8192;

  // Request and response field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned NBYTES_W = 16;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 2;

  // Configuration register.
  localparam int unsigned HEAP_BYTES_W   = 17;
  localparam int unsigned HEAP_BYTES_RST = 65536;
  localparam int unsigned PADDR_W        = 2;
  localparam int unsigned PDATA_W        = 32;

  // Width of a request size in 8-byte words including the header word.
  localparam int unsigned NEED_W = 14;
  // Heap length in words as given by the register.
  localparam int unsigned LEN_W  = HEAP_BYTES_W - 3;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PADDR_W-1:0]  paddr_t;

  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_INIT  = 2'd2;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_NOFIT   = 2'd1;
  localparam status_t STATUS_CORRUPT = 2'd2;

  localparam paddr_t REG_HEAP_BYTES = 2'd0;

endpackage

// ----- rtl/ilha_if.sv -----
// ----------------------------------------------------------------------------
// ilha_req_if / ilha_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface ilha_req_if;
  logic                        valid;
  logic                        ready;
  ilha_pkg::op_t               op;
  logic [ilha_pkg::NBYTES_W-1:0] nbytes;
  logic [ilha_pkg::ADDR_W-1:0]   payload_addr;

  modport source (output valid, op, nbytes, payload_addr, input ready);
  modport sink   (input valid, op, nbytes, payload_addr, output ready);
endinterface

interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  ilha_pkg::status_t           status;
  logic [ilha_pkg::ADDR_W-1:0] result_addr;

  modport source (output valid, status, result_addr, input ready);
  modport sink   (input valid, status, result_addr, output ready);
endinterface

// ----- rtl/ilha_store.sv -----
// ----------------------------------------------------------------------------
// ilha_store
// Header memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilha_store #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/ilha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilha_ctrl
// Sequencer that walks block headers for allocate and free and writes the first header for initialize.
// ----------------------------------------------------------------------------
module ilha_ctrl #(
  parameter int unsigned HeapWords = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ilha_pkg::HEAP_BYTES_W-1:0]   heap_bytes_i,
  ilha_req_if.sink                            req_i,
  ilha_rsp_if.source                          rsp_o
);
  import ilha_pkg::*;

  localparam int unsigned WW = $clog2(HeapWords + 1);
  localparam int unsigned AW = $clog2(HeapWords);
  localparam int unsigned SW = WW + 1;
  localparam int unsigned XW = SW + 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = (WW > LEN_W) ? WW : LEN_W;
  localparam int unsigned RstWords = (HeapWords < (HEAP_BYTES_RST / 8)) ?
                                     HeapWords : (HEAP_BYTES_RST / 8);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_CHK  = 4'd1;
  localparam logic [3:0] S_A_EVAL = 4'd2;
  localparam logic [3:0] S_A_SPL  = 4'd3;
  localparam logic [3:0] S_F_EVAL = 4'd4;
  localparam logic [3:0] S_M_CHK  = 4'd5;
  localparam logic [3:0] S_M_EVAL = 4'd6;
  localparam logic [3:0] S_P_CHK  = 4'd7;
  localparam logic [3:0] S_P_EVAL = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [WW-1:0]     heap_end_q, heap_end_d;
  logic              ovr_q, ovr_d, rd_ovr_q;
  logic [XW-1:0]     cur_q, cur_d, base_q, base_d, sz_q, sz_d;
  logic [XW-1:0]     blk_q, blk_d, blk_sz_q, blk_sz_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic              phase_q, phase_d;
  status_t           status_q, status_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              rsp_valid_q, rsp_valid_d;
  status_t           rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0] rsp_addr_q, rsp_addr_d;

  logic              we, re;
  logic [XW-1:0]     waddr, raddr;
  logic [DW-1:0]     wdata, mem_rdata, rdata;
  logic [XW-1:0]     rd_sz, heap_end_x, nxt, free_blk;
  logic              rd_al;
  logic [CW-1:0]     len_w;

  ilha_store #(.Depth(HeapWords), .Width(DW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Entry 0 holds the reset block until it is first written.
  assign rdata      = rd_ovr_q ? {SW'(heap_end_q), 1'b0} : mem_rdata;
  assign rd_sz      = XW'(rdata[DW-1:1]);
  assign rd_al      = rdata[0];
  assign heap_end_x = XW'(heap_end_q);
  assign free_blk   = XW'(req_i.payload_addr[ADDR_W-1:3]) - XW'(1);
  assign len_w      = CW'(heap_bytes_i[HEAP_BYTES_W-1:3]);

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.result_addr = rsp_addr_q;

  always_comb begin
    state_d      = state_q;
    heap_end_d   = heap_end_q;
    ovr_d        = ovr_q;
    cur_d        = cur_q;
    base_d       = base_q;
    sz_d         = sz_q;
    blk_d        = blk_q;
    blk_sz_d     = blk_sz_q;
    need_d       = need_q;
    phase_d      = phase_q;
    status_d     = status_q;
    addr_d       = addr_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_addr_d   = rsp_addr_q;
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    nxt   = '0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        status_d = STATUS_OK;
        addr_d   = '0;
        if (req_i.valid) begin
          state_d = S_DONE;
          case (req_i.op)
            OP_ALLOC: begin
              if (req_i.nbytes == '0) begin
                status_d = STATUS_NOFIT;
              end else begin
                need_d  = NEED_W'(({1'b0, req_i.nbytes} + 17'd7) >> 3) + NEED_W'(1);
                cur_d   = '0;
                state_d = S_A_CHK;
              end
            end
            OP_FREE: begin
              if (req_i.payload_addr != '0 && req_i.payload_addr[2:0] == 3'd0 &&
                  free_blk < heap_end_x) begin
                blk_d   = free_blk;
                re      = 1'b1;
                raddr   = free_blk;
                state_d = S_F_EVAL;
              end
            end
            OP_INIT: begin
              heap_end_d = (len_w > CW'(HeapWords)) ? WW'(HeapWords) : WW'(len_w);
              we    = 1'b1;
              waddr = '0;
              wdata = {SW'(heap_end_d), 1'b0};
            end
            default: ;
          endcase
        end
      end
      S_A_CHK: begin
        if (cur_q >= heap_end_x) begin
          status_d = STATUS_NOFIT;
          state_d  = S_DONE;
        end else begin
          re      = 1'b1;
          raddr   = cur_q;
          state_d = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        nxt = cur_q + rd_sz;
        if (rd_sz == '0 || nxt > heap_end_x) begin
          status_d = STATUS_CORRUPT;
          state_d  = S_DONE;
        end else if (!rd_al && rd_sz >= XW'(need_q)) begin
          addr_d = ADDR_W'((cur_q + XW'(1)) << 3);
          we     = 1'b1;
          if (rd_sz - XW'(need_q) >= XW'(2)) begin
            waddr   = cur_q + XW'(need_q);
            wdata   = {SW'(rd_sz - XW'(need_q)), 1'b0};
            state_d = S_A_SPL;
          end else begin
            waddr   = cur_q;
            wdata   = {SW'(rd_sz), 1'b1};
            state_d = S_DONE;
          end
        end else begin
          cur_d   = nxt;
          state_d = S_A_CHK;
        end
      end
      S_A_SPL: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = {SW'(need_q), 1'b1};
        state_d = S_DONE;
      end
      S_F_EVAL: begin
        we      = 1'b1;
        waddr   = blk_q;
        wdata   = {SW'(rd_sz), 1'b0};
        base_d  = blk_q;
        sz_d    = rd_sz;
        phase_d = 1'b0;
        state_d = S_M_CHK;
      end
      S_M_CHK: begin
        nxt = base_q + sz_q;
        if (nxt >= heap_end_x) begin
          blk_sz_d = sz_q;
          cur_d    = '0;
          state_d  = phase_q ? S_DONE : S_P_CHK;
        end else begin
          re      = 1'b1;
          raddr   = nxt;
          state_d = S_M_EVAL;
        end
      end
      S_M_EVAL: begin
        if (rd_sz == '0 || rd_al) begin
          blk_sz_d = sz_q;
          cur_d    = '0;
          state_d  = phase_q ? S_DONE : S_P_CHK;
        end else begin
          sz_d    = sz_q + rd_sz;
          we      = 1'b1;
          waddr   = base_q;
          wdata   = {SW'(sz_d), 1'b0};
          state_d = S_M_CHK;
        end
      end
      S_P_CHK: begin
        if (cur_q >= heap_end_x) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr   = cur_q;
          state_d = S_P_EVAL;
        end
      end
      S_P_EVAL: begin
        nxt = cur_q + rd_sz;
        if (rd_sz == '0 || nxt > blk_q) begin
          state_d = S_DONE;
        end else if (nxt == blk_q) begin
          if (!rd_al) begin
            sz_d    = rd_sz + blk_sz_q;
            we      = 1'b1;
            waddr   = cur_q;
            wdata   = {SW'(sz_d), 1'b0};
            base_d  = cur_q;
            phase_d = 1'b1;
            state_d = S_M_CHK;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cur_d   = nxt;
          state_d = S_P_CHK;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_addr_d   = addr_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (we && waddr == '0) begin
      ovr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_end_q  <= WW'(RstWords);
      ovr_q       <= 1'b1;
      rd_ovr_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_end_q  <= heap_end_d;
      ovr_q       <= ovr_d;
      rd_ovr_q    <= re && raddr == '0 && ovr_q;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    base_q       <= base_d;
    sz_q         <= sz_d;
    blk_q        <= blk_d;
    blk_sz_q     <= blk_sz_d;
    need_q       <= need_d;
    phase_q      <= phase_d;
    status_q     <= status_d;
    addr_q       <= addr_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
  end

  // A header is only evaluated in the cycle after its read was issued.
  a_eval_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_EVAL) |-> ($past(state_q) == S_A_CHK))
    else $error("allocate evaluate without a preceding header read");

  a_pred_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_EVAL) |-> ($past(state_q) == S_P_CHK))
    else $error("predecessor evaluate without a preceding header read");

  // A new response is loaded only after the previous one has left.
  a_rsp_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> rsp_valid_q && $stable(rsp_addr_q))
    else $error("pending response overwritten");

endmodule

// ----- rtl/implicit_list_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit heap allocator over an implicit list of 8-byte-granular blocks.
// ----------------------------------------------------------------------------
// Each request walks block headers: every block header that the walk visits
// costs a read of the header memory, then its evaluation. An allocate walks
// the blocks before the fit and then the fit itself, and a free adds forward
// merging plus a predecessor walk from the start of the heap. Initialize
// writes the first header directly. The single read port of the header
// memory paces each walk. The request channel is ready only while the
// sequencer is idle; a finished response sits in an output register, so the
// next request can be accepted while it waits to be taken. After reset the
// heap holds one free block of 65536 bytes (clamped to the heap capacity);
// no clearing pass is needed. The heap_bytes register takes effect at the
// next initialize request.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator #(
  parameter int unsigned HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ilha_req_if.sink                     req_i,
  ilha_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  ilha_pkg::paddr_t             paddr,
  input  logic [ilha_pkg::PDATA_W-1:0] pwdata,
  output logic [ilha_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import ilha_pkg::*;

  logic [HEAP_BYTES_W-1:0] heap_bytes_q;

  // The port never waits; writes land on the access cycle.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_bytes_q <= HEAP_BYTES_W'(HEAP_BYTES_RST);
    end else if (psel && penable && pwrite && paddr == REG_HEAP_BYTES) begin
      heap_bytes_q <= pwdata[HEAP_BYTES_W-1:0];
    end
  end

  // Only one register exists; other addresses read back as zero.
  always_comb begin
    prdata = '0;
    if (paddr == REG_HEAP_BYTES) begin
      prdata = PDATA_W'(heap_bytes_q);
    end
  end

  // The sequencer owns the header memory and both channels.
  ilha_ctrl #(.HeapWords(HEAP_WORDS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_bytes_i (heap_bytes_q),
    .req_i        (req_i),
    .rsp_o        (rsp_o)
  );

endmodule
